/* sv/pmed_pkg.sv */
// Shared constants, types and arithmetic helpers for the mono error diffusion block.
`timescale 1ns / 1ps
`default_nettype none
package pmed_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int IDX_W         = 8;
  localparam int LEVEL_W       = 6;
  localparam int ENTRY_W       = 3 * LEVEL_W;
  localparam int LUMA_W        = 6;
  localparam int ERR_W         = 5;
  localparam int SUM_W         = 8;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 8;

  localparam logic signed [SUM_W-1:0] WHITE_THRESHOLD = 8'sd32;
  localparam logic signed [SUM_W-1:0] WHITE_LEVEL     = 8'sd63;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_PIXEL = 1'b1
  } action_t;

  typedef struct packed {
    logic [LUMA_W-1:0]       brightness;
    logic                    line_start;
    logic signed [ERR_W-1:0] start_error;
  } pix_item_t;

  // Weighted brightness (5r + 9g + 2b) / 16 of one palette entry.
  function automatic logic [LUMA_W-1:0] entry_luma(input logic [ENTRY_W-1:0] entry);
    logic [9:0] acc;
    acc = 10'(entry[17:12]) * 10'd5 + 10'(entry[11:6]) * 10'd9 + 10'(entry[5:0]) * 10'd2;
    return acc[9:4];
  endfunction

  // Division by three, truncated toward zero, for values in -32..32.
  function automatic logic signed [ERR_W-1:0] div3(input logic signed [SUM_W-1:0] value);
    logic [5:0]  mag;
    logic [10:0] prod;
    logic [4:0]  quot;
    mag  = value[SUM_W-1] ? 6'(-value) : 6'(value);
    prod = 11'(mag) * 11'd43;
    quot = 5'(prod[10:7]);
    return value[SUM_W-1] ? -$signed(quot) : $signed(quot);
  endfunction

endpackage
`default_nettype wire

/* sv/pmed_front.sv */
// Front part: accepts beats, writes the palette and looks up pixel brightness.
`timescale 1ns / 1ps
`default_nettype none
module pmed_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [pmed_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic                          s_tuser,
  input  wire logic                          s_tlast,
  output logic                               push,
  output pmed_pkg::pix_item_t                push_item,
  input  wire logic                          q_full
);
  import pmed_pkg::*;

  logic [ENTRY_W-1:0]      mem [PALETTE_DEPTH];
  logic [ENTRY_W-1:0]      rd_data;
  logic                    stage_valid;
  logic                    stage_in_range;
  logic                    stage_line_start;
  logic signed [ERR_W-1:0] stage_start_error;

  logic                    accept;
  logic                    in_range;
  logic [ADDR_W-1:0]       addr;
  logic [IDX_W-1:0]        idx;
  action_t                 act;

  assign idx      = s_tdata[7:0];
  assign act      = action_t'(s_tuser);
  assign addr     = ADDR_W'(idx);
  assign in_range = {1'b0, idx} < (IDX_W + 1)'(PALETTE_DEPTH);
  assign accept   = s_tvalid && s_tready;
  assign push     = stage_valid && !q_full;
  assign s_tready = !stage_valid || !q_full;

  always_ff @(posedge clk) begin
    if (accept && act == ACT_WRITE && in_range) begin
      mem[addr] <= {s_tdata[13:8], s_tdata[19:14], s_tdata[25:20]};
    end
    if (accept && act == ACT_PIXEL) begin
      rd_data           <= mem[addr];
      stage_in_range    <= in_range;
      stage_line_start  <= s_tlast;
      stage_start_error <= $signed(s_tdata[30:26]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept && act == ACT_PIXEL) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_comb begin
    push_item.brightness  = stage_in_range ? entry_luma(rd_data) : '0;
    push_item.line_start  = stage_line_start;
    push_item.start_error = stage_start_error;
  end

endmodule
`default_nettype wire

/* sv/pmed_queue.sv */
// Two-entry queue of looked-up pixels between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module pmed_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire pmed_pkg::pix_item_t push_item,
  output logic                     full,
  input  wire logic                pop,
  output pmed_pkg::pix_item_t      pop_item,
  output logic                     not_empty
);
  import pmed_pkg::*;

  pix_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("Queue count exceeds its depth.");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Push into a full queue.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("Pop from an empty queue.");

endmodule
`default_nettype wire

/* sv/pmed_back.sv */
// Back part: adds the carried error, thresholds and holds the output beat.
`timescale 1ns / 1ps
`default_nettype none
module pmed_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           not_empty,
  output logic                                pop,
  input  wire pmed_pkg::pix_item_t            pop_item,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [pmed_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import pmed_pkg::*;

  logic signed [ERR_W-1:0] carried_error;
  logic signed [ERR_W-1:0] carried_error_next;
  logic                    mono_pixel;
  logic                    mono_pixel_next;
  logic signed [ERR_W-1:0] base_error;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] err;

  assign pop     = not_empty && (!m_tvalid || m_tready);
  assign m_tdata = {(OUT_DATA_W - 1)'(0), mono_pixel};

  always_comb begin
    base_error = pop_item.line_start ? pop_item.start_error : carried_error;
    sum        = $signed({2'b00, pop_item.brightness}) + SUM_W'(base_error);
    if (sum > WHITE_THRESHOLD) begin
      mono_pixel_next = 1'b1;
      err             = sum - WHITE_LEVEL;
    end else begin
      mono_pixel_next = 1'b0;
      err             = sum;
    end
    carried_error_next = div3(err);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mono_pixel <= mono_pixel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      carried_error <= '0;
    end else begin
      if (pop) begin
        m_tvalid      <= 1'b1;
        carried_error <= carried_error_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_error_range: assert property (@(posedge clk) disable iff (rst)
      carried_error >= -5'sd10 && carried_error <= 5'sd10)
    else $error("Carried error left its range.");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(mono_pixel))
    else $error("Output beat changed while stalled.");
  a_error_only_on_pop: assert property (@(posedge clk) disable iff (rst)
      !pop |=> $stable(carried_error))
    else $error("Carried error changed without a pixel.");

endmodule
`default_nettype wire

/* sv/palette_mono_error_diffusion.sv */
// Top level of the palette to one-bit error diffusion converter.
//
// The input channel (s_*) carries one item per beat. s_tuser selects the kind:
// 0 writes a palette entry, 1 converts one pixel. s_tlast marks the first
// pixel of a line, whose start error then replaces the carried error.
// The output channel (m_*) carries one beat per pixel, the dithered bit in
// m_tdata[0]; palette writes give no output beat.
// A pixel beat accepted at the input is read from the palette into the lookup
// stage, then moved into the two-entry queue and then loaded into the output
// register. Throughput is one beat per clock on both sides while the receiver
// does not stall; each beat uses the single-port palette memory once.
// A palette write followed at once by a pixel of the same entry sees the new
// value.
// Reset clears the carried error, the queue and both valid flags; the
// palette keeps its contents and must be written before its entries are used.
// When the receiver stalls, the output register, the queue and the lookup
// stage fill up, and s_tready drops once all of them are occupied.
`timescale 1ns / 1ps
`default_nettype none
module palette_mono_error_diffusion (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // Fields from bit 0: entry_index[7:0], red_level[13:8], green_level[19:14],
  // blue_level[25:20], start_error[30:26], zero bit 31.
  input  wire logic [31:0] s_tdata,
  // Fields from bit 0: action.
  input  wire logic [0:0]  s_tuser,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // Fields from bit 0: mono_pixel, zero bits 7:1.
  output logic [7:0]       m_tdata
);
  import pmed_pkg::*;

  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_not_empty;
  pix_item_t push_item;
  pix_item_t pop_item;

  pmed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser[0]),
    .s_tlast   (s_tlast),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  pmed_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (q_not_empty)
  );

  pmed_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_not_empty),
    .pop       (pop),
    .pop_item  (pop_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the palette to one-bit error diffusion converter.
`timescale 1ns / 1ps
module tb;
  import pmed_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES  = 60;

  typedef struct {
    action_t           kind;
    logic [7:0]        index;
    logic [5:0]        red;
    logic [5:0]        green;
    logic [5:0]        blue;
    logic              line_first;
    logic signed [4:0] start_err;
  } dither_req_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;

  logic [17:0] palette_levels [256];
  bit          entry_written [256];
  int          written_list [$];
  int          carry_err = 0;
  bit          mono_expected [$];
  int          mismatches = 0;
  bit          quiet = 1'b0;
  int          hold_count = 0;
  int          cycle_count = 0;

  palette_mono_error_diffusion DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver stalls at random, or for a counted stretch when asked to.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_count > 0) begin
        m_tready <= 1'b0;
        hold_count--;
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= 9);
      end
    end
  end

  function automatic void dither_model(input dither_req_t it, output bit has_pix,
                                       output bit mono);
    int          luma;
    int          level_sum;
    int          err;
    logic [17:0] levels;
    has_pix = 1'b0;
    mono    = 1'b0;
    if (it.kind == ACT_WRITE) begin
      palette_levels[it.index] = {it.red, it.green, it.blue};
      if (!entry_written[it.index]) begin
        entry_written[it.index] = 1'b1;
        written_list.push_back(int'(it.index));
      end
    end else begin
      levels = palette_levels[it.index];
      luma = (5 * int'(levels[17:12]) + 9 * int'(levels[11:6]) + 2 * int'(levels[5:0])) >> 4;
      level_sum = luma;
      if (it.line_first)
        level_sum += int'(it.start_err);
      else
        level_sum += carry_err;
      if (level_sum > 32) begin
        mono = 1'b1;
        err  = level_sum - 63;
      end else begin
        err = level_sum;
      end
      carry_err = err / 3;
      has_pix   = 1'b1;
    end
  endfunction

  function automatic dither_req_t write_req(input int idx, input int r, input int g,
                                            input int b);
    dither_req_t it;
    it.kind       = ACT_WRITE;
    it.index      = 8'(idx);
    it.red        = 6'(r);
    it.green      = 6'(g);
    it.blue       = 6'(b);
    it.line_first = 1'($urandom_range(1));
    it.start_err  = 5'($urandom);
    return it;
  endfunction

  function automatic dither_req_t pixel_req(input int idx, input bit first, input int serr);
    dither_req_t it;
    it.kind       = ACT_PIXEL;
    it.index      = 8'(idx);
    it.red        = 6'($urandom);
    it.green      = 6'($urandom);
    it.blue       = 6'($urandom);
    it.line_first = first;
    it.start_err  = 5'(serr);
    return it;
  endfunction

  function automatic int random_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  task automatic send_item(input dither_req_t it);
    bit has_pix;
    bit mono;
    if (!quiet && $urandom_range(99) < 9) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, it.start_err, it.blue, it.green, it.red, it.index};
    s_tuser  <= it.kind;
    s_tlast  <= it.line_first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    dither_model(it, has_pix, mono);
    if (has_pix)
      mono_expected.push_back(mono);
  endtask

  always @(posedge clk) begin : check_output
    bit want;
    if (!rst && m_tvalid && m_tready) begin
      if (mono_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Output beat %h arrived with no pixel pending", m_tdata);
      end else begin
        want = mono_expected.pop_front();
        if (m_tdata !== {7'b0, want}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Pixel mismatch: expected %h, got %h", {7'b0, want}, m_tdata);
        end
      end
    end
  end

  // Black and white entries at both ends of the index range and a mid-grey entry
  // at index 128, with the start error at its extremes.
  task automatic test_palette_extremes();
    send_item(write_req(0, 0, 0, 0));
    send_item(write_req(255, 63, 63, 63));
    send_item(write_req(128, 32, 32, 32));
    send_item(pixel_req(0, 1'b1, -16));
    send_item(pixel_req(255, 1'b0, $urandom));
    send_item(pixel_req(255, 1'b1, 15));
    send_item(pixel_req(0, 1'b1, 0));
  endtask

  // A mid-grey line sits on the threshold, so the carried error flips it.
  task automatic test_mid_grey_line();
    send_item(pixel_req(128, 1'b1, 1));
    repeat (5) send_item(pixel_req(128, 1'b0, $urandom));
  endtask

  // Writes between pixels keep the carried error, and a pixel right after a
  // write to its entry sees the new levels.
  task automatic test_write_between_pixels();
    send_item(pixel_req(128, 1'b1, -1));
    send_item(write_req(128, 63, 0, 0));
    send_item(pixel_req(128, 1'b0, $urandom));
    send_item(write_req(7, 1, 2, 3));
    send_item(pixel_req(7, 1'b0, $urandom));
  endtask

  // The receiver holds off while pixels keep coming, so the input stalls.
  task automatic test_output_backpressure();
    quiet = 1'b1;
    hold_count = HOLD_CYCLES;
    for (int k = 0; k < 40; k++)
      send_item(pixel_req(random_written(), k % 10 == 0, $urandom));
    quiet = 1'b0;
  endtask

  // Lines of random length with palette writes mixed in, plus stray line
  // starts, and one stretch without any idling.
  task automatic test_random_lines();
    int sent;
    int seg_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet = (sent >= 500 && sent < 700);
      seg_len = $urandom_range(1, 40);
      for (int pos = 0; pos < seg_len && sent < RANDOM_ITEMS; pos++) begin
        if ($urandom_range(99) < 20)
          send_item(write_req($urandom_range(255), $urandom_range(63), $urandom_range(63),
                              $urandom_range(63)));
        else
          send_item(pixel_req(random_written(), pos == 0 || $urandom_range(99) < 3,
                              $urandom));
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    s_tlast  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_palette_extremes();
    test_mid_grey_line();
    test_write_between_pixels();
    test_output_backpressure();
    test_random_lines();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (mono_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
